// ===== rtl/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, codes and helpers for the hex record encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

  // field widths fixed by the item format
  localparam int CNT_W   = 5;
  localparam int ADDR_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int OP_W    = 2;
  localparam int CFG_AW  = 3;

  // item opcodes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_SEEK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLOSE = 2'd2;

  // register index of the enable bit (word address bit of paddr)
  localparam logic REG_ENABLE = 1'b0;

  // fixed characters
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;

  // header of one queued record
  typedef struct packed {
    logic              last;   // record closes the item's output
    logic              eof;    // end-of-file record, else data record
    logic [CNT_W-1:0]  count;  // data bytes in the record
    logic [ADDR_W-1:0] addr;   // load address of the record
  } rec_hdr_t;

  // nibble to uppercase hex digit
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      return 8'h30 + ext;
    end else begin
      return 8'h37 + ext;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ihex_front.sv =====
// ----------------------------------------------------------------------------
// ihex_front
// Accepts command words, fills the record buffer, tracks the load address
// and hands finished record descriptors to the record queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ihex_front #(
  parameter int RECORD_BYTES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              enable,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ihex_pkg::OP_W-1:0]         opcode,
  input  wire logic [ihex_pkg::ADDR_W-1:0]       data_word,
  input  wire logic [ihex_pkg::ADDR_W-1:0]       seek_address,
  output logic                                   push_valid,
  input  wire logic                              push_ready,
  output ihex_pkg::rec_hdr_t                     push_hdr,
  output logic [RECORD_BYTES*ihex_pkg::BYTE_W-1:0] push_data
);

  localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam logic [ihex_pkg::CNT_W-1:0] FULL_CNT = ihex_pkg::CNT_W'(RECORD_BYTES);
  localparam logic [ihex_pkg::ADDR_W-1:0] FULL_ADV = ihex_pkg::ADDR_W'(RECORD_BYTES);

  logic [ihex_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ihex_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic                        eof_pend_r, eof_pend_nxt;
  logic [ihex_pkg::BYTE_W-1:0] buf_r    [RECORD_BYTES];
  logic [ihex_pkg::BYTE_W-1:0] buf_nxt  [RECORD_BYTES];
  logic [ihex_pkg::BYTE_W-1:0] buf_hi   [RECORD_BYTES];
  logic [ihex_pkg::BYTE_W-1:0] buf_both [RECORD_BYTES];
  logic [ihex_pkg::BYTE_W-1:0] snap     [RECORD_BYTES];

  logic [ihex_pkg::CNT_W-1:0]  cnt_p1, cnt_p2;
  logic [IDX_W-1:0]            hi_idx, lo_idx;
  logic [ihex_pkg::BYTE_W-1:0] hi_byte, lo_byte;
  logic                        accept;

  assign in_ready = push_ready && !eof_pend_r;
  assign accept   = in_valid && in_ready;

  assign cnt_p1  = cnt_r + ihex_pkg::CNT_W'(1);
  assign cnt_p2  = cnt_r + ihex_pkg::CNT_W'(2);
  assign hi_idx  = cnt_r[IDX_W-1:0];
  assign lo_idx  = cnt_p1[IDX_W-1:0];
  assign hi_byte = data_word[15:8];
  assign lo_byte = data_word[7:0];

  // buffer images with the high byte, and with both bytes, written in
  always_comb begin
    for (int i = 0; i < RECORD_BYTES; i++) begin
      buf_hi[i]   = (hi_idx == IDX_W'(i)) ? hi_byte : buf_r[i];
      buf_both[i] = (lo_idx == IDX_W'(i)) ? lo_byte : buf_hi[i];
    end
  end

  // command decode and record hand-off
  always_comb begin
    cnt_nxt      = cnt_r;
    addr_nxt     = addr_r;
    eof_pend_nxt = eof_pend_r;
    buf_nxt      = buf_r;
    snap         = buf_r;
    push_valid   = 1'b0;
    push_hdr     = '0;
    push_hdr.addr = addr_r;

    if (eof_pend_r) begin
      // second record of a close that flushed data first
      if (push_ready) begin
        push_valid    = 1'b1;
        push_hdr.last = 1'b1;
        push_hdr.eof  = 1'b1;
        eof_pend_nxt  = 1'b0;
      end
    end else if (accept && enable) begin
      case (opcode)
        ihex_pkg::OP_PUT: begin
          if (cnt_p1 == FULL_CNT) begin
            // high byte fills the record, low byte opens the next
            snap           = buf_hi;
            push_valid     = 1'b1;
            push_hdr.last  = 1'b1;
            push_hdr.count = FULL_CNT;
            buf_nxt        = buf_hi;
            buf_nxt[0]     = lo_byte;
            cnt_nxt        = ihex_pkg::CNT_W'(1);
            addr_nxt       = addr_r + FULL_ADV;
          end else if (cnt_p2 == FULL_CNT) begin
            snap           = buf_both;
            push_valid     = 1'b1;
            push_hdr.last  = 1'b1;
            push_hdr.count = FULL_CNT;
            buf_nxt        = buf_both;
            cnt_nxt        = '0;
            addr_nxt       = addr_r + FULL_ADV;
          end else begin
            buf_nxt = buf_both;
            cnt_nxt = cnt_p2;
          end
        end
        ihex_pkg::OP_SEEK: begin
          if (cnt_r != '0) begin
            push_valid     = 1'b1;
            push_hdr.last  = 1'b1;
            push_hdr.count = cnt_r;
          end
          cnt_nxt  = '0;
          addr_nxt = {seek_address[ihex_pkg::ADDR_W-2:0], 1'b0};
        end
        ihex_pkg::OP_CLOSE: begin
          push_valid = 1'b1;
          if (cnt_r != '0) begin
            // flush the open data record; the end record follows from eof_pend_r once the queue is ready
            push_hdr.count = cnt_r;
            addr_nxt       = addr_r + ihex_pkg::ADDR_W'(cnt_r);
            cnt_nxt        = '0;
            eof_pend_nxt   = 1'b1;
          end else begin
            push_hdr.last = 1'b1;
            push_hdr.eof  = 1'b1;
          end
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  // pack the record bytes for the queue
  always_comb begin
    for (int i = 0; i < RECORD_BYTES; i++) begin
      push_data[i*ihex_pkg::BYTE_W +: ihex_pkg::BYTE_W] = snap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      addr_r     <= '0;
      eof_pend_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      addr_r     <= addr_nxt;
      eof_pend_r <= eof_pend_nxt;
    end
  end

  // record buffer holds payload only
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  // the buffer never holds a full record between items
  a_cnt_below_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < FULL_CNT)
    else $error("record buffer count reached full size");

  // a pending end record always follows an emptied buffer
  a_eof_pend_empty: assert property (@(posedge clk) disable iff (!rst_n)
    eof_pend_r |-> (cnt_r == '0))
    else $error("end record pending with data in buffer");

endmodule

`default_nettype wire

// ===== rtl/ihex_queue.sv =====
// ----------------------------------------------------------------------------
// ihex_queue
// Two-entry queue of record descriptors between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ihex_queue #(
  parameter int DATA_W = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire ihex_pkg::rec_hdr_t push_hdr,
  input  wire logic [DATA_W-1:0]  push_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output ihex_pkg::rec_hdr_t      pop_hdr,
  output logic [DATA_W-1:0]       pop_data
);

  localparam logic [1:0] DEPTH = 2'd2;

  ihex_pkg::rec_hdr_t mem_hdr_r  [2];
  logic [DATA_W-1:0]  mem_data_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         count_r;
  logic               do_push, do_pop;

  assign push_ready = (count_r != DEPTH);
  assign pop_valid  = (count_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_hdr    = mem_hdr_r[rd_ptr_r];
  assign pop_data   = mem_data_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_hdr_r[wr_ptr_r]  <= push_hdr;
      mem_data_r[wr_ptr_r] <= push_data;
    end
  end

  // fill level stays within the storage
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH)
    else $error("record queue overflow");

endmodule

`default_nettype wire

// ===== rtl/ihex_back.sv =====
// ----------------------------------------------------------------------------
// ihex_back
// Walks one queued record and sends its text one character per word:
// colon, hex byte pairs, checksum and newline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ihex_back #(
  parameter int RECORD_BYTES = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                pop_valid,
  output logic                                     pop_ready,
  input  wire ihex_pkg::rec_hdr_t                  pop_hdr,
  input  wire logic [RECORD_BYTES*ihex_pkg::BYTE_W-1:0] pop_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [ihex_pkg::BYTE_W-1:0]              out_char,
  output logic                                     out_last
);

  localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HI,
    S_LO,
    S_NL
  } state_t;

  state_t                                state_r;
  ihex_pkg::rec_hdr_t                    hdr_r;
  logic [RECORD_BYTES*ihex_pkg::BYTE_W-1:0] data_r;
  logic [ihex_pkg::CNT_W-1:0]            idx_r;
  logic [ihex_pkg::BYTE_W-1:0]           sum_r;
  logic [ihex_pkg::BYTE_W-1:0]           out_char_r;
  logic                                  out_last_r;
  logic                                  out_valid_r;

  logic                                  adv;
  logic [ihex_pkg::CNT_W-1:0]            end_idx;
  logic [ihex_pkg::CNT_W-1:0]            data_pos;
  logic [ihex_pkg::BYTE_W-1:0]           cur_byte;

  assign adv       = !out_valid_r || out_ready;
  assign pop_ready = adv && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // byte order: count, address high, address low, type, data, checksum
  assign end_idx  = hdr_r.count + ihex_pkg::CNT_W'(4);
  assign data_pos = idx_r - ihex_pkg::CNT_W'(4);

  always_comb begin
    case (idx_r)
      ihex_pkg::CNT_W'(0): cur_byte = {3'b000, hdr_r.count};
      ihex_pkg::CNT_W'(1): cur_byte = hdr_r.addr[15:8];
      ihex_pkg::CNT_W'(2): cur_byte = hdr_r.addr[7:0];
      ihex_pkg::CNT_W'(3): cur_byte = {7'b0000000, hdr_r.eof};
      default: begin
        if (idx_r == end_idx) begin
          cur_byte = 8'h00 - sum_r;
        end else begin
          cur_byte = data_r[data_pos[IDX_W-1:0]*ihex_pkg::BYTE_W +: ihex_pkg::BYTE_W];
        end
      end
    endcase
  end

  // character sequencer with registered output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else if (adv) begin
      case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            hdr_r       <= pop_hdr;
            data_r      <= pop_data;
            idx_r       <= '0;
            sum_r       <= '0;
            out_char_r  <= ihex_pkg::CHAR_COLON;
            out_last_r  <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_HI;
          end else begin
            out_valid_r <= 1'b0;
            out_last_r  <= 1'b0;
          end
        end
        S_HI: begin
          out_char_r  <= ihex_pkg::hex_char(cur_byte[7:4]);
          out_last_r  <= 1'b0;
          out_valid_r <= 1'b1;
          state_r     <= S_LO;
        end
        S_LO: begin
          out_char_r  <= ihex_pkg::hex_char(cur_byte[3:0]);
          out_last_r  <= 1'b0;
          out_valid_r <= 1'b1;
          sum_r       <= sum_r + cur_byte;
          if (idx_r == end_idx) begin
            state_r <= S_NL;
          end else begin
            idx_r   <= idx_r + ihex_pkg::CNT_W'(1);
            state_r <= S_HI;
          end
        end
        S_NL: begin
          out_char_r  <= ihex_pkg::CHAR_NL;
          out_last_r  <= hdr_r.last;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  // newline comes only after the checksum byte
  a_nl_after_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NL) |-> (idx_r == end_idx))
    else $error("newline reached before checksum");

  // item end is marked only on a newline
  a_last_on_newline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_char_r == ihex_pkg::CHAR_NL))
    else $error("last flag on a character other than newline");

endmodule

`default_nettype wire

// ===== rtl/intel_hex_record_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_encoder_unit
// Turns put / seek / close command words into hex record text, one ASCII
// character per output word.
//
//   port group | dir | role
//   in_*       | in  | command words: tuser opcode, tdata word and seek address
//   out_*      | out | text characters, tlast on the item's final character
//   cfg_*      | in  | register port, register 0 bit 0 enables command handling
//
// A put stores two bytes of the data word and, when the buffer fills,
// queues a record. A record of n data bytes leaves the character
// sequencer as 2n+12 characters.
// The record queue holds two records; input stalls only when it is full
// or while a close queues its end record after a data record.
// Synchronous active-low reset clears enable, counters and queue; no
// memory sweep follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_encoder_unit #(
  parameter int RECORD_BYTES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [31:0]                   in_tdata,  // data_word, seek_address
  input  wire logic [1:0]                    in_tuser,  // opcode
  // result channel
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [7:0]                         out_tdata, // text_char
  output logic                               out_tlast, // last_char
  // register port
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [ihex_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int DATA_W = RECORD_BYTES * ihex_pkg::BYTE_W;

  logic               enable_r;
  logic               cfg_wr;
  logic               push_valid, push_ready;
  logic               pop_valid, pop_ready;
  ihex_pkg::rec_hdr_t push_hdr, pop_hdr;
  logic [DATA_W-1:0]  push_data, pop_data;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_wr && (cfg_paddr[2] == ihex_pkg::REG_ENABLE)) begin
      enable_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == ihex_pkg::REG_ENABLE) ? {31'b0, enable_r} : 32'b0;

  // command side
  ihex_front #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .enable       (enable_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .opcode       (in_tuser),
    .data_word    (in_tdata[15:0]),
    .seek_address (in_tdata[31:16]),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_hdr     (push_hdr),
    .push_data    (push_data)
  );

  // record queue
  ihex_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_hdr   (push_hdr),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_hdr    (pop_hdr),
    .pop_data   (pop_data)
  );

  // text side
  ihex_back #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_hdr   (pop_hdr),
    .pop_data  (pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire
